// ===== design/oaht_pkg.sv =====
// Shared types, codes and helpers of the open address hash table.
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;

  localparam int DefTableDepth = 1024;
  localparam int DefKeyBytes   = 8;

  // Fixed field widths
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int OUT_W   = 3;
  localparam int SLOT_W  = 10;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 3;
  localparam int DIV_W   = 11;  // widest small dividend: byte sum or coefficient sum

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Outcomes
  localparam logic [OUT_W-1:0] OUT_FOUND    = 3'd0;
  localparam logic [OUT_W-1:0] OUT_INSERTED = 3'd1;
  localparam logic [OUT_W-1:0] OUT_UPDATED  = 3'd2;
  localparam logic [OUT_W-1:0] OUT_NOTFOUND = 3'd3;
  localparam logic [OUT_W-1:0] OUT_FULL     = 3'd4;

  // Cell status codes
  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_OCCUPIED = 2'd1;
  localparam logic [1:0] ST_DELETED  = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_PROBE_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SQUARE_COEF  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LINEAR_COEF  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PROBE_LIMIT  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_CELLS_IN_USE = 3'd4;

  // Request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } rem_req_t;

  // Mask of the key bytes that take part in hash and compare
  function automatic logic [KEY_W-1:0] key_mask(input int kb);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < kb) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== design/oaht_if.sv =====
// Request and response channel interfaces of the hash table.
`timescale 1ns / 1ps
`default_nettype none
interface oaht_req_if import oaht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key_bytes;
  logic [VALUE_W-1:0] new_value;
  modport source (output valid, mode, key_bytes, new_value, input ready);
  modport sink   (input valid, mode, key_bytes, new_value, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OUT_W-1:0]   outcome;
  logic [VALUE_W-1:0] read_value;
  logic [SLOT_W-1:0]  slot_index;
  modport source (output valid, outcome, read_value, slot_index, input ready);
  modport sink   (input valid, outcome, read_value, slot_index, output ready);
endinterface
`default_nettype wire

// ===== design/oaht_ram.sv =====
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/oaht_rem.sv =====
// Bit-serial remainder unit: small dividend modulo the cell count.
`timescale 1ns / 1ps
`default_nettype none
module oaht_rem import oaht_pkg::*; #(
  parameter int NW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rem_req_t      req,
  input  wire logic [NW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      rem
);
  localparam int CW = $clog2(DIV_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DIV_W-1:0] q;
  logic [NW:0]      trial;

  assign trial = {rem, q[DIV_W-1]};

  // One dividend bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
        q    <= req.dividend;
        rem  <= '0;
      end else if (busy) begin
        q <= {q[DIV_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) rem <= NW'(trial - {1'b0, divisor});
        else rem <= trial[NW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/open_address_hash_table_core.sv =====
// Top level: open address hash table with linear or quadratic probing.
// Sequence per request: three serial remainders (start position, step, stride), then a
// walk of the cell RAMs of 1 .. probe_limit probes (one probe when probe_limit is zero).
// Throughput: one request at a time; the next word is taken only once the result word is issued.
// Reset: synchronous; a clearing pass over every cell empties the status
// RAM, during which no request word is taken; registers return to defaults.
`timescale 1ns / 1ps
`default_nettype none
module open_address_hash_table_core import oaht_pkg::*; #(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int KEY_BYTES   = DefKeyBytes
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  oaht_req_if.sink               req,
  oaht_rsp_if.source             rsp
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = AW + 1;
  localparam logic [KEY_W-1:0] KeyMask = key_mask(KEY_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD_H, S_MOD_D, S_MOD_S, S_ISSUE, S_CHECK, S_FINISH
  } state_t;

  state_t state;

  // Configuration
  logic             probe_mode;
  logic [7:0]       square_coef, linear_coef;
  logic [CFG_W-1:0] probe_limit, cells_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode   <= 1'b0;
      square_coef  <= 8'd1;
      linear_coef  <= 8'd0;
      probe_limit  <= CFG_W'(16);
      cells_in_use <= CFG_W'(1024);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROBE_MODE:   probe_mode   <= cfg_data[0];
        REG_SQUARE_COEF:  square_coef  <= cfg_data[7:0];
        REG_LINEAR_COEF:  linear_coef  <= cfg_data[7:0];
        REG_PROBE_LIMIT:  probe_limit  <= cfg_data;
        REG_CELLS_IN_USE: cells_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective cell count and probe limit
  logic [31:0]      cells32;
  logic [NW-1:0]    n_cells;
  logic [CFG_W-1:0] limit;
  assign cells32 = 32'(cells_in_use);
  always_comb begin
    if (cells32 == 32'd0) n_cells = NW'(1);
    else if (cells32 > 32'(TABLE_DEPTH)) n_cells = NW'(TABLE_DEPTH);
    else n_cells = NW'(cells32);
  end
  assign limit = (probe_limit == '0) ? CFG_W'(1) : probe_limit;

  // Linear probing is the quadratic walk with no square term and unit step
  logic [7:0] a_eff, b_eff;
  assign a_eff = probe_mode ? square_coef : 8'd0;
  assign b_eff = probe_mode ? linear_coef : 8'd1;

  // Request registers
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  // Byte sum of the key
  logic [DIV_W-1:0] byte_sum;
  always_comb begin
    byte_sum = '0;
    for (int b = 0; b < KEY_BYTES; b++) byte_sum = byte_sum + DIV_W'(key[8*b +: 8]);
  end

  // Remainder unit
  rem_req_t      rreq;
  logic          rgo;
  logic          rdone;
  logic [NW-1:0] rrem;
  always_comb begin
    rreq.start = rgo;
    unique case (state)
      S_MOD_H: rreq.dividend = byte_sum;
      S_MOD_D: rreq.dividend = DIV_W'(a_eff) + DIV_W'(b_eff);
      default: rreq.dividend = DIV_W'({a_eff, 1'b0});
    endcase
  end

  oaht_rem #(.NW(NW)) u_rem (
    .clk(clk), .rst(rst), .req(rreq), .divisor(n_cells), .done(rdone), .rem(rrem)
  );

  // Start the remainder unit on each new dividend
  always_ff @(posedge clk) begin
    if (rst) rgo <= 1'b0;
    else rgo <= (state == S_IDLE && req.valid)
                || ((state == S_MOD_H || state == S_MOD_D) && rdone);
  end

  // Walk registers
  logic [AW-1:0]    pos, step, stride, free_slot, hit_slot;
  logic [CFG_W-1:0] probe_cnt;
  logic             have_free, matched;
  logic [VALUE_W-1:0] hit_value;

  // Next position and next step, one compare and subtract each
  logic [NW-1:0] pos_sum, step_sum;
  logic [AW-1:0] pos_next, step_next;
  assign pos_sum   = {1'b0, pos} + {1'b0, step};
  assign pos_next  = (pos_sum >= n_cells) ? AW'(pos_sum - n_cells) : pos_sum[AW-1:0];
  assign step_sum  = {1'b0, step} + {1'b0, stride};
  assign step_next = (step_sum >= n_cells) ? AW'(step_sum - n_cells) : step_sum[AW-1:0];

  // Cell RAMs
  logic [1:0]               st_rd, st_wd;
  logic                     st_we, kv_we;
  logic [AW-1:0]            st_wa, kv_wa, rd_addr, clr_addr;
  logic [KEY_W+VALUE_W-1:0] kv_rd, kv_wd;

  oaht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_status (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(rd_addr), .rdata(st_rd)
  );
  oaht_ram #(.WIDTH(KEY_W + VALUE_W), .DEPTH(TABLE_DEPTH)) u_cells (
    .clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(kv_wd), .raddr(rd_addr), .rdata(kv_rd)
  );

  // Probe evaluation
  logic is_occ, is_match, walk_end;
  assign is_occ   = (st_rd == ST_OCCUPIED);
  assign is_match = is_occ && (kv_rd[KEY_W+VALUE_W-1:VALUE_W] == key);
  assign walk_end = is_match || (st_rd == ST_EMPTY)
                    || ({1'b0, probe_cnt} + 1'b1 >= {1'b0, limit});

  logic out_valid, out_free;
  logic [OUT_W-1:0]   out_outcome;
  logic [VALUE_W-1:0] out_value;
  logic [SLOT_W-1:0]  out_slot;
  assign out_free = !out_valid || rsp.ready;

  // Read address: next position while walking
  assign rd_addr = (state == S_CHECK) ? pos_next : pos;

  // Write back at the end of a request, or sweep after reset
  logic ins, rem_hit;
  assign ins     = (mode == MODE_INSERT);
  assign rem_hit = (mode == MODE_REMOVE) && matched;
  always_comb begin
    st_we = 1'b0;
    st_wa = clr_addr;
    st_wd = ST_EMPTY;
    kv_we = 1'b0;
    kv_wa = matched ? hit_slot : free_slot;
    kv_wd = {key, value};
    if (state == S_CLEAR) begin
      st_we = 1'b1;
    end else if (state == S_FINISH && out_free) begin
      kv_we = ins && (matched || have_free);
      if (ins && !matched && have_free) begin
        st_we = 1'b1;
        st_wa = free_slot;
        st_wd = ST_OCCUPIED;
      end else if (rem_hit) begin
        st_we = 1'b1;
        st_wa = hit_slot;
        st_wd = ST_DELETED;
      end
    end
  end

  // Result of the finished walk
  logic [OUT_W-1:0]   res_outcome;
  logic [VALUE_W-1:0] res_value;
  logic [AW-1:0]      res_slot;
  logic [31:0]        res_slot32;
  always_comb begin
    res_outcome = OUT_NOTFOUND;
    res_value   = '0;
    res_slot    = '0;
    priority if (ins) begin
      if (matched) begin
        res_outcome = OUT_UPDATED;
        res_slot    = hit_slot;
      end else if (have_free) begin
        res_outcome = OUT_INSERTED;
        res_slot    = free_slot;
      end else begin
        res_outcome = OUT_FULL;
      end
    end else if (matched) begin
      res_outcome = OUT_FOUND;
      res_slot    = hit_slot;
      if (mode != MODE_REMOVE) res_value = hit_value;
    end
  end
  assign res_slot32 = 32'(res_slot);

  assign req.ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            mode  <= req.mode;
            key   <= req.key_bytes & KeyMask;
            value <= req.new_value;
            state <= S_MOD_H;
          end
        end
        S_MOD_H: begin
          if (rdone) begin
            pos   <= rrem[AW-1:0];
            state <= S_MOD_D;
          end
        end
        S_MOD_D: begin
          if (rdone) begin
            step  <= rrem[AW-1:0];
            state <= S_MOD_S;
          end
        end
        S_MOD_S: begin
          if (rdone) begin
            stride    <= rrem[AW-1:0];
            probe_cnt <= '0;
            have_free <= 1'b0;
            matched   <= 1'b0;
            state     <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_CHECK;
        S_CHECK: begin
          if (is_match) begin
            matched   <= 1'b1;
            hit_slot  <= pos;
            hit_value <= kv_rd[VALUE_W-1:0];
          end else if (!is_occ && !have_free) begin
            have_free <= 1'b1;
            free_slot <= pos;
          end
          if (walk_end) begin
            state <= S_FINISH;
          end else begin
            pos       <= pos_next;
            step      <= step_next;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_outcome <= res_outcome;
            out_value   <= res_value;
            out_slot    <= res_slot32[SLOT_W-1:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.outcome    = out_outcome;
  assign rsp.read_value = out_value;
  assign rsp.slot_index = out_slot;
endmodule
`default_nettype wire

// ===== design/oaht_checker.sv =====
// Port-level checks of the hash table response channel, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module oaht_checker import oaht_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [OUT_W-1:0]   outcome,
  input wire logic [VALUE_W-1:0] read_value,
  input wire logic [SLOT_W-1:0]  slot_index
);
  // Hold a stalled response word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome) && $stable(read_value)
                               && $stable(slot_index))
    else $error("stalled response word changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outcome <= OUT_FULL)
    else $error("outcome code out of range");

  a_noslot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (outcome == OUT_NOTFOUND || outcome == OUT_FULL) |-> slot_index == '0)
    else $error("slot given for a failed request");

  a_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && outcome != OUT_FOUND |-> read_value == '0)
    else $error("value given without a found key");
endmodule

bind open_address_hash_table_core oaht_checker u_oaht_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .outcome(rsp.outcome), .read_value(rsp.read_value), .slot_index(rsp.slot_index)
);
`default_nettype wire
